>>> rtl/speed_pid_with_integral_clamp_core_assert.svh
// ----------------------------------------------------------------------------
// Speed PID core assertion macros
// Shared assertion forms used by the core's port checker.
// ----------------------------------------------------------------------------
`ifndef SPEED_PID_WITH_INTEGRAL_CLAMP_CORE_ASSERT_SVH
`define SPEED_PID_WITH_INTEGRAL_CLAMP_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SPIDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SPIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SPIDC_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spidc_pkg.sv
// ----------------------------------------------------------------------------
// Speed PID package
// Widths, register indexes and pipeline word types for the speed PID core.
// ----------------------------------------------------------------------------
package spidc_pkg;

  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned SUM_W     = 33;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned PP_W      = GAIN_W + ERR_W;
  localparam int unsigned IP_W      = GAIN_W + INTEG_W;
  localparam int unsigned DP_W      = GAIN_W + DIFF_W;
  localparam int unsigned ACC_W     = 50;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DRIVE_W   = 16;

  typedef enum logic [1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_INTEGRAL_LIMIT
  } cfg_index_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
    logic                      clamped;
  } integ_word_t;

  typedef struct packed {
    logic signed [PP_W-1:0] p_prod;
    logic signed [IP_W-1:0] i_prod;
    logic signed [DP_W-1:0] d_prod;
    logic                   clamped;
  } prod_word_t;

endpackage

>>> rtl/spidc_integ.sv
// ----------------------------------------------------------------------------
// Speed PID error and integral stage
// Forms the error, updates the clamped integral and the error change.
// ----------------------------------------------------------------------------
module spidc_integ (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [spidc_pkg::SPEED_W-1:0]  measured_speed,
  input  logic signed [spidc_pkg::SPEED_W-1:0]  target_speed,
  input  logic        [spidc_pkg::LIMIT_W-1:0]  integral_limit,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output spidc_pkg::integ_word_t                out_word
);
  import spidc_pkg::*;

  logic signed [INTEG_W-1:0] error_integral;
  logic signed [ERR_W-1:0]   previous_error;

  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   lim_pos;
  logic signed [SUM_W-1:0]   lim_neg;
  logic signed [SUM_W-1:0]   sum_clamped;
  logic                      clamped;
  logic signed [DIFF_W-1:0]  diff;
  logic                      accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign err     = {measured_speed[SPEED_W-1], measured_speed}
                 - {target_speed[SPEED_W-1], target_speed};
  assign sum     = {error_integral[INTEG_W-1], error_integral}
                 + {{(SUM_W-ERR_W){err[ERR_W-1]}}, err};
  assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, integral_limit});
  assign lim_neg = -lim_pos;
  assign diff    = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};

  // The limit never exceeds 2^31-1, so the clamped sum fits the integral.
  always_comb begin
    sum_clamped = sum;
    clamped     = 1'b0;
    priority if (sum > lim_pos) begin
      sum_clamped = lim_pos;
      clamped     = 1'b1;
    end else if (sum < lim_neg) begin
      sum_clamped = lim_neg;
      clamped     = 1'b1;
    end else begin
      sum_clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      error_integral <= '0;
      previous_error <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        error_integral <= sum_clamped[INTEG_W-1:0];
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.err     <= err;
      out_word.integ   <= sum_clamped[INTEG_W-1:0];
      out_word.diff    <= diff;
      out_word.clamped <= clamped;
    end
  end

endmodule

>>> rtl/spidc_mult.sv
// ----------------------------------------------------------------------------
// Speed PID product stage
// Multiplies error, integral and error change by their gains.
// ----------------------------------------------------------------------------
module spidc_mult (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  spidc_pkg::integ_word_t  in_word,
  input  spidc_pkg::gains_t       gains,
  output logic                    out_valid,
  input  logic                    out_ready,
  output spidc_pkg::prod_word_t   out_word
);
  import spidc_pkg::*;

  logic signed [PP_W-1:0] p_prod;
  logic signed [IP_W-1:0] i_prod;
  logic signed [DP_W-1:0] d_prod;
  logic                   accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign p_prod = PP_W'(in_word.err)   * PP_W'(gains.prop);
  assign i_prod = IP_W'(in_word.integ) * IP_W'(gains.integ);
  assign d_prod = DP_W'(in_word.diff)  * DP_W'(gains.deriv);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.p_prod  <= p_prod;
      out_word.i_prod  <= i_prod;
      out_word.d_prod  <= d_prod;
      out_word.clamped <= in_word.clamped;
    end
  end

endmodule

>>> rtl/spidc_sat.sv
// ----------------------------------------------------------------------------
// Speed PID sum and saturation stage
// Adds the products, drops the fraction and saturates into the result register.
// ----------------------------------------------------------------------------
module spidc_sat (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  spidc_pkg::prod_word_t                in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [spidc_pkg::DRIVE_W-1:0] drive,
  output logic                                 integral_clamped
);
  import spidc_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'(64'sd1 <<< (DRIVE_W - 1 + FRAC_BITS));
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  logic signed [ACC_W-1:0]   acc;
  logic signed [DRIVE_W-1:0] drive_next;
  logic                      accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign acc = ACC_W'(in_word.p_prod) + ACC_W'(in_word.i_prod) + ACC_W'(in_word.d_prod);

  // Inside the range the shift is a plain bit select, which floors.
  always_comb begin
    priority if (acc >= SAT_HI) begin
      drive_next = DRIVE_MAX;
    end else if (acc < SAT_LO) begin
      drive_next = DRIVE_MIN;
    end else begin
      drive_next = acc[FRAC_BITS +: DRIVE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive            <= drive_next;
      integral_clamped <= in_word.clamped;
    end
  end

endmodule

>>> rtl/speed_pid_with_integral_clamp_core.sv
// An accepted word is registered in the error and integral stage, then in the product
// stage, then in the sum and saturation stage, whose register drives the result port.
// Throughput: one word per cycle; each of the three stages holds a word and
// moves on whenever the stage after it is empty or is being emptied.
// The integral and previous error update in the first stage as a word enters.
// Reset (rst, synchronous) empties the pipeline, clears integral and previous
// error and loads the gain and limit registers with their defaults.
// ----------------------------------------------------------------------------
// Speed PID core
// Positional PID speed loop with clamped integral, three-stage pipeline.
// ----------------------------------------------------------------------------
module speed_pid_with_integral_clamp_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // measured_speed, target_speed
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,   // drive
  output logic                                m_tuser,   // integral_clamped
  input  logic                                cfg_wr_en,
  input  spidc_pkg::cfg_index_t               cfg_index,
  input  logic [spidc_pkg::LIMIT_W-1:0]       cfg_wr_data
);
  import spidc_pkg::*;

  gains_t                     gains;
  logic        [LIMIT_W-1:0]  integral_limit;

  integ_word_t                integ_word;
  logic                       integ_valid;
  logic                       integ_ready;
  prod_word_t                 prod_word;
  logic                       prod_valid;
  logic                       prod_ready;
  logic signed [DRIVE_W-1:0]  drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop     <= GAIN_W'(2304);
      gains.integ    <= '0;
      gains.deriv    <= '0;
      integral_limit <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:      gains.prop     <= cfg_wr_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:     gains.integ    <= cfg_wr_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:     gains.deriv    <= cfg_wr_data[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT: integral_limit <= cfg_wr_data;
      endcase
    end
  end

  spidc_integ u_integ (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .measured_speed (s_tdata[15:0]),
    .target_speed   (s_tdata[31:16]),
    .integral_limit (integral_limit),
    .out_valid      (integ_valid),
    .out_ready      (integ_ready),
    .out_word       (integ_word)
  );

  spidc_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (integ_valid),
    .in_ready  (integ_ready),
    .in_word   (integ_word),
    .gains     (gains),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_word  (prod_word)
  );

  spidc_sat u_sat (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (prod_valid),
    .in_ready         (prod_ready),
    .in_word          (prod_word),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .drive            (drive),
    .integral_clamped (m_tuser)
  );

  assign m_tdata = drive;

endmodule

>>> rtl/spidc_checker.sv
// ----------------------------------------------------------------------------
// Speed PID port checker
// Watches the core's stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "speed_pid_with_integral_clamp_core_assert.svh"

module spidc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // The input side only stalls when every stage is full and the result waits.
  `SPIDC_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready, "input stalled while pipeline had room")

  // Reset leaves the pipeline empty and ready for a word.
  `SPIDC_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !m_tvalid && s_tready, "pipeline not empty after reset")

  `SPIDC_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed or dropped")

endmodule

bind speed_pid_with_integral_clamp_core spidc_checker u_spidc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Speed PID core testbench
// Streams speed samples into the core, predicts each drive word and integral
// clamp flag in a scoreboard, and checks the words in order. Gains and the
// integral limit are changed between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spidc_pkg::*;

  localparam int       HALF_PERIOD  = 10;
  localparam int       RESET_CYCLES = 12;
  localparam int       DRAIN_CYCLES = 8;
  localparam int       HOLD_CYCLES  = 300;
  localparam int       STUCK_LIMIT  = 4000;
  localparam int       REPORT_MAX   = 10;
  localparam int       PHASE_WORDS  = 100;
  localparam longint   DRIVE_SPAN   = 64'sd8388608;  // 32768 in signed Q41.8 (8 fraction bits)
  localparam bit [30:0] LIMIT_MAX   = 31'h7FFF_FFFF;

  typedef struct {
    logic [15:0] drive;
    logic        clamped;
  } drive_word_t;

  // Mirrors the gains, the limit, the integral and the last error, and keeps
  // the drive words still owed by the core.
  class drive_predictor;
    shortint     kp = 2304;
    shortint     ki = 0;
    shortint     kd = 0;
    longint      limit = 64'h7FFF_FFFF;
    longint      integral = 0;
    longint      prev_err = 0;
    drive_word_t expected_drives[$];
    int          mismatches = 0;

    function void set_reg(cfg_index_t idx, logic [30:0] val);
      case (idx)
        CFG_PROP_GAIN:      kp = shortint'(val[15:0]);
        CFG_INTEG_GAIN:     ki = shortint'(val[15:0]);
        CFG_DERIV_GAIN:     kd = shortint'(val[15:0]);
        CFG_INTEGRAL_LIMIT: limit = longint'(val);
        default:            ;
      endcase
    endfunction

    function void note_sample(logic [15:0] meas, logic [15:0] tgt);
      shortint     m;
      shortint     t;
      longint      err;
      longint      sum;
      longint      acc;
      drive_word_t w;
      m = meas;
      t = tgt;
      err = longint'(m) - longint'(t);
      sum = integral + err;
      w.clamped = 1'b0;
      // A sum that lands exactly on the limit is kept and not flagged.
      if (sum > limit) begin
        sum = limit;
        w.clamped = 1'b1;
      end else if (sum < -limit) begin
        sum = -limit;
        w.clamped = 1'b1;
      end
      integral = sum;
      acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * (err - prev_err);
      prev_err = err;
      if (acc >= DRIVE_SPAN) begin
        w.drive = 16'h7FFF;
      end else if (acc < -DRIVE_SPAN) begin
        w.drive = 16'h8000;
      end else begin
        w.drive = 16'(acc >>> 8);
      end
      expected_drives.push_back(w);
    endfunction

    function void report(string what, drive_word_t exp_w, logic [15:0] drive, logic clamped);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: %s: expected drive %h clamped %b, got drive %h clamped %b",
                 $realtime, what, exp_w.drive, exp_w.clamped, drive, clamped);
      end
    endfunction

    function void check_drive(logic [15:0] drive, logic clamped);
      drive_word_t w;
      if (expected_drives.size() == 0) begin
        w.drive = 'x;
        w.clamped = 'x;
        report("unexpected word", w, drive, clamped);
        return;
      end
      w = expected_drives.pop_front();
      if (drive !== w.drive || clamped !== w.clamped) begin
        report("mismatch", w, drive, clamped);
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // measured_speed, target_speed
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // drive
  logic        m_tuser;          // integral_clamped
  logic        cfg_wr_en = 1'b0;
  cfg_index_t  cfg_index = CFG_PROP_GAIN;
  logic [30:0] cfg_wr_data = '0;

  drive_predictor sb;
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  bit             hold_request = 1'b0;
  int             hold_left = 0;
  int             stuck_cycles = 0;

  speed_pid_with_integral_clamp_core u_top (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request so the core
  // fills up and pushes back on its input.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_sample(s_tdata[15:0], s_tdata[31:16]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_drive(m_tdata, m_tuser);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [30:0] gain_word(shortint g);
    logic [14:0] junk;
    junk = 15'($urandom);
    return {junk, g};
  endfunction

  function automatic shortint pick_gain();
    if ($urandom_range(3) == 0) begin
      return shortint'($urandom);
    end
    return shortint'(int'($urandom_range(2048)) - 1024);
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(3))
      0:       return 31'($urandom_range(1000));
      1:       return 31'($urandom_range(200000));
      2:       return 31'($urandom);
      default: return LIMIT_MAX;
    endcase
  endfunction

  task automatic send_word(input logic [15:0] meas, input logic [15:0] tgt);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tgt, meas};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly errors of a few hundred so the integral walks toward the limit,
  // with full-range and extreme samples mixed in.
  task automatic send_random();
    logic [15:0] tgt;
    logic [15:0] meas;
    logic [15:0] corner[4];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    tgt = 16'($urandom);
    case ($urandom_range(9))
      0, 1: meas = 16'($urandom);
      2: begin
        meas = corner[$urandom_range(3)];
        tgt  = corner[$urandom_range(3)];
      end
      default: meas = tgt + 16'($urandom_range(600)) - 16'd300;
    endcase
    send_word(meas, tgt);
  endtask

  // The extra edge lets the word accepted at the last edge reach the scoreboard.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; the core must be empty.
  task automatic load_settings(input logic [30:0] kp, input logic [30:0] ki,
                               input logic [30:0] kd, input logic [30:0] lim);
    logic [30:0] vals[4];
    vals = '{kp, ki, kd, lim};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= cfg_index_t'(i);
      cfg_wr_data <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_index_t'(i), vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    sb = new;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset gains: proportional only, large errors saturate both ways.
    send_word(16'h0000, 16'h0000);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h0001, 16'h0000);
    send_word(16'h0000, 16'h0001);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000);
    send_word(16'hFFFF, 16'h0001);

    // Small limit: clamping at both ends, and sums landing exactly on it.
    wait_drained();
    load_settings(gain_word(16'sd1), gain_word(16'sd256), gain_word(-16'sd256), 31'd100);
    send_word(16'd50, 16'd0);
    send_word(16'd60, 16'd0);
    send_word(16'd0, 16'd0);
    send_word(-16'd200, 16'd0);
    send_word(-16'd1, 16'd0);
    send_word(16'd3, 16'd7);
    send_word(16'd101, -16'd100);

    // Zero limit pins the integral; an error of -1 checks the floor shift.
    wait_drained();
    load_settings(gain_word(16'sd1), gain_word(16'sd32767), gain_word(16'sd0), 31'd0);
    send_word(16'd0, 16'd1);
    send_word(16'd1, 16'd0);
    send_word(16'd5, 16'd0);
    send_word(-16'd5, 16'd0);

    // Extreme gains with the widest limit.
    wait_drained();
    load_settings(gain_word(16'sh8000), gain_word(16'sd32767), gain_word(16'sh8000),
                  LIMIT_MAX);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h0000, 16'h0000);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          load_settings(gain_word(pick_gain()), gain_word(pick_gain()),
                        gain_word(pick_gain()), 31'($urandom_range(200000)));
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          load_settings(gain_word(pick_gain()), gain_word(pick_gain()),
                        gain_word(pick_gain()), LIMIT_MAX);
          tx_idle_pct = 47;
          rx_stall_pct = 0;
        end
        2: begin
          load_settings(gain_word(pick_gain()), gain_word(pick_gain()),
                        gain_word(pick_gain()), 31'($urandom));
          tx_idle_pct = 0;
          rx_stall_pct = 47;
        end
        3: begin
          load_settings(gain_word(pick_gain()), gain_word(pick_gain()),
                        gain_word(pick_gain()), 31'd0);
          tx_idle_pct = 34;
          rx_stall_pct = 34;
        end
        4: begin
          load_settings(gain_word(16'sd32767), gain_word(16'sh8000),
                        gain_word(16'sd32767), 31'($urandom_range(1000)));
          tx_idle_pct = 47;
          rx_stall_pct = 0;
        end
        default: begin
          load_settings(gain_word(pick_gain()), gain_word(pick_gain()),
                        gain_word(pick_gain()), pick_limit());
          tx_idle_pct = 34;
          rx_stall_pct = 34;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 0 && n == 30) begin
          hold_request = 1'b1;
        end
        send_random();
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/spidc_pkg.sv
rtl/spidc_integ.sv
rtl/spidc_mult.sv
rtl/spidc_sat.sv
rtl/speed_pid_with_integral_clamp_core.sv
rtl/spidc_checker.sv
dv/tb_top.sv
